[hdl/philox_counter_rng_block_defines.svh]
// assertion macros used by the philox serializer module
`ifndef PHILOX_COUNTER_RNG_BLOCK_DEFINES_SVH
`define PHILOX_COUNTER_RNG_BLOCK_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define PCRNG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define PCRNG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[hdl/pcrng_pkg.sv]
// types and constants of the philox counter rng block
package pcrng_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockW     = 30;
  localparam int unsigned CntW       = 3;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [WordW-1:0] MulA  = 32'hD2511F53;
  localparam logic [WordW-1:0] MulB  = 32'hCD9E8D57;
  localparam logic [WordW-1:0] WeylA = 32'h9E3779B9;
  localparam logic [WordW-1:0] WeylB = 32'hBB67AE85;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyLow       = 8'd0,
    RegKeyHigh      = 8'd1,
    RegCounterBase  = 8'd2,
    RegElementTotal = 8'd3
  } pcrng_reg_e;

  // counter and key words travelling down the round chain
  typedef struct packed {
    logic [WordW-1:0] c0;
    logic [WordW-1:0] c1;
    logic [WordW-1:0] c2;
    logic [WordW-1:0] c3;
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
  } pcrng_state_t;

  // sideband: block number and how many lanes go out
  typedef struct packed {
    logic [BlockW-1:0] blk;
    logic [CntW-1:0]   cnt;
  } pcrng_tag_t;

endpackage

[hdl/philox_counter_rng_block.sv]
// philox4x32 generator: an accepted beat is registered in stage 0, in each round cell
// and in the serializer; one round cell per stage, a new block may enter every cycle
// while the output keeps up; a block leaves the chain only once the one-word output
// register has sent all of the prior block; blocks beyond element_total leave no result
// reset clears all config registers to zero and every valid flag; no clearing pass
// cfg_ready_o is always high
module philox_counter_rng_block #(
  parameter int unsigned ROUND_COUNT = pcrng_pkg::RoundCount
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcrng_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcrng_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pcrng_pkg::BlockW-1:0]   in_block_number_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pcrng_pkg::WordW-1:0]    out_random_word_o,
  output logic [pcrng_pkg::WordW-1:0]    out_element_index_o,
  output logic                           out_last_of_block_o
);

  logic [pcrng_pkg::WordW-1:0]    key_low_q, key_high_q, element_total_q;
  logic [pcrng_pkg::CfgDataW-1:0] counter_base_q;

  logic                         en, take;
  logic [pcrng_pkg::WordW-1:0]  base_idx;
  logic [pcrng_pkg::WordW:0]    rem;
  logic                         any_lane;
  pcrng_pkg::pcrng_tag_t        tag_d;
  pcrng_pkg::pcrng_state_t      st_d;

  logic                    vld [ROUND_COUNT+1];
  pcrng_pkg::pcrng_tag_t   tag [ROUND_COUNT+1];
  pcrng_pkg::pcrng_state_t st  [ROUND_COUNT+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q       <= '0;
      key_high_q      <= '0;
      counter_base_q  <= '0;
      element_total_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcrng_pkg::RegKeyLow:       key_low_q       <= cfg_data_i[pcrng_pkg::WordW-1:0];
        pcrng_pkg::RegKeyHigh:      key_high_q      <= cfg_data_i[pcrng_pkg::WordW-1:0];
        pcrng_pkg::RegCounterBase:  counter_base_q  <= cfg_data_i;
        pcrng_pkg::RegElementTotal: element_total_q <= cfg_data_i[pcrng_pkg::WordW-1:0];
        default: ;
      endcase
    end
  end

  // whole chain moves together; it holds only when a finished block cannot leave
  assign en         = ~vld[ROUND_COUNT] | take;
  assign in_stall_o = ~en;

  assign base_idx = {in_block_number_i, 2'b00};
  assign rem      = {1'b0, element_total_q} - {1'b0, base_idx};
  assign any_lane = element_total_q > base_idx;

  always_comb begin
    tag_d.blk = in_block_number_i;
    tag_d.cnt = (rem >= 33'd4) ? 3'd4 : rem[2:0];
    st_d.c0   = '0;
    st_d.c1   = '0;
    st_d.c2   = '0;
    st_d.c3   = '0;
    st_d.k0   = '0;
    st_d.k1   = '0;
    {st_d.c1, st_d.c0} = counter_base_q
                       + {{(pcrng_pkg::CfgDataW-pcrng_pkg::BlockW){1'b0}}, in_block_number_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid_i & any_lane;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag[0] <= tag_d;
      st[0]  <= st_d;
    end
  end

  // the key enters at the first round; cells bump it for their successor
  pcrng_pkg::pcrng_state_t st0_key;
  always_comb begin
    st0_key    = st[0];
    st0_key.k0 = key_low_q;
    st0_key.k1 = key_high_q;
  end

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    pcrng_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[r]),
      .tag_i   (tag[r]),
      .st_i    ((r == 0) ? st0_key : st[r]),
      .valid_o (vld[r+1]),
      .tag_o   (tag[r+1]),
      .st_o    (st[r+1])
    );
  end

  pcrng_serializer u_ser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (vld[ROUND_COUNT]),
    .tag_i               (tag[ROUND_COUNT]),
    .st_i                (st[ROUND_COUNT]),
    .take_o              (take),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_random_word_o   (out_random_word_o),
    .out_element_index_o (out_element_index_o),
    .out_last_of_block_o (out_last_of_block_o)
  );

endmodule

[hdl/pcrng_round_cell.sv]
// one philox round as a pipeline cell
module pcrng_round_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pcrng_pkg::pcrng_tag_t   tag_i,
  input  pcrng_pkg::pcrng_state_t st_i,
  output logic                valid_o,
  output pcrng_pkg::pcrng_tag_t   tag_o,
  output pcrng_pkg::pcrng_state_t st_o
);

  logic [2*pcrng_pkg::WordW-1:0] pa, pb;
  pcrng_pkg::pcrng_state_t st_d, st_q;
  pcrng_pkg::pcrng_tag_t   tag_q;
  logic                    valid_q;

  assign pa = {{pcrng_pkg::WordW{1'b0}}, st_i.c0} * {{pcrng_pkg::WordW{1'b0}}, pcrng_pkg::MulA};
  assign pb = {{pcrng_pkg::WordW{1'b0}}, st_i.c2} * {{pcrng_pkg::WordW{1'b0}}, pcrng_pkg::MulB};

  always_comb begin
    st_d.c0 = pb[2*pcrng_pkg::WordW-1:pcrng_pkg::WordW] ^ st_i.c1 ^ st_i.k0;
    st_d.c1 = pb[pcrng_pkg::WordW-1:0];
    st_d.c2 = pa[2*pcrng_pkg::WordW-1:pcrng_pkg::WordW] ^ st_i.c3 ^ st_i.k1;
    st_d.c3 = pa[pcrng_pkg::WordW-1:0];
    // key for the following round
    st_d.k0 = st_i.k0 + pcrng_pkg::WeylA;
    st_d.k1 = st_i.k1 + pcrng_pkg::WeylB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign st_o    = st_q;

endmodule

[hdl/pcrng_serializer.sv]
// hands the words of a block, up to four, out one beat at a time
`include "philox_counter_rng_block_defines.svh"

module pcrng_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  pcrng_pkg::pcrng_tag_t        tag_i,
  input  pcrng_pkg::pcrng_state_t      st_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pcrng_pkg::WordW-1:0]  out_random_word_o,
  output logic [pcrng_pkg::WordW-1:0]  out_element_index_o,
  output logic                         out_last_of_block_o
);

  logic [3:0][pcrng_pkg::WordW-1:0] words_q;
  logic [pcrng_pkg::BlockW-1:0]     blk_q;
  logic [pcrng_pkg::CntW-1:0]       cnt_q;
  logic [1:0]                       lane_d, lane_q;
  logic                             valid_d, valid_q;
  logic                             last, beat, load;

  assign last   = ({1'b0, lane_q} == (cnt_q - 3'd1));
  assign beat   = valid_q & ~out_stall_i;
  assign take_o = ~valid_q | (beat & last);
  assign load   = valid_i & take_o;

  always_comb begin
    valid_d = valid_q;
    lane_d  = lane_q;
    if (load) begin
      valid_d = 1'b1;
      lane_d  = 2'd0;
    end else if (beat) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        lane_d = lane_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lane_q  <= 2'd0;
    end else begin
      valid_q <= valid_d;
      lane_q  <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      words_q <= {st_i.c3, st_i.c2, st_i.c1, st_i.c0};
      blk_q   <= tag_i.blk;
      cnt_q   <= tag_i.cnt;
    end
  end

  assign out_valid_o         = valid_q;
  assign out_random_word_o   = words_q[lane_q];
  assign out_element_index_o = {blk_q, lane_q};
  assign out_last_of_block_o = last;

  `PCRNG_ASSERT(a_lane_in_range, !valid_q || (cnt_q != 3'd0 && {1'b0, lane_q} < cnt_q), "lane beyond block count")
  `PCRNG_ASSERT_NEXT(a_lane_steps, beat && !last, valid_q && lane_q == $past(lane_q) + 2'd1, "lane did not advance")
  `PCRNG_ASSERT_NEXT(a_block_ends, beat && last && !valid_i, !valid_q, "word repeated after last beat")
  `PCRNG_ASSERT_NEXT(a_load_lane0, load, valid_q && lane_q == 2'd0, "new block does not start at lane zero")

endmodule

[dv/philox_word_scoreboard_pkg.sv]
// scoreboard class with a philox4x32 word predictor for the counter rng block
`timescale 1ns / 1ps
package philox_word_scoreboard_pkg;

  typedef bit [3:0][pcrng_pkg::WordW-1:0] lane_words_t;

  typedef struct {
    logic [pcrng_pkg::WordW-1:0] word;
    logic [pcrng_pkg::WordW-1:0] index;
    logic                        last;
  } philox_word_t;

  class philox_word_scoreboard;
    philox_word_t               expected_words[$];
    bit [pcrng_pkg::WordW-1:0]  key_low;
    bit [pcrng_pkg::WordW-1:0]  key_high;
    bit [63:0]                  counter_base;
    bit [pcrng_pkg::WordW-1:0]  element_total;
    int unsigned                mismatches;

    function new();
      key_low       = '0;
      key_high      = '0;
      counter_base  = '0;
      element_total = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [pcrng_pkg::CfgIdxW-1:0] index,
                            logic [pcrng_pkg::CfgDataW-1:0] data);
      case (index)
        pcrng_pkg::RegKeyLow:       key_low       = data[pcrng_pkg::WordW-1:0];
        pcrng_pkg::RegKeyHigh:      key_high      = data[pcrng_pkg::WordW-1:0];
        pcrng_pkg::RegCounterBase:  counter_base  = data;
        pcrng_pkg::RegElementTotal: element_total = data[pcrng_pkg::WordW-1:0];
        default: ;
      endcase
    endfunction

    function lane_words_t philox_rounds(bit [63:0] ctr);
      bit [pcrng_pkg::WordW-1:0]   c0, c1, c2, c3, k0, k1, n0, n2;
      bit [2*pcrng_pkg::WordW-1:0] pa, pb;
      lane_words_t                 lanes;
      c0 = ctr[31:0];
      c1 = ctr[63:32];
      c2 = '0;
      c3 = '0;
      k0 = key_low;
      k1 = key_high;
      for (int r = 0; r < pcrng_pkg::RoundCount; r++) begin
        // key schedule bumps ahead of every round but the first
        if (r != 0) begin
          k0 = k0 + pcrng_pkg::WeylA;
          k1 = k1 + pcrng_pkg::WeylB;
        end
        pa = {32'd0, c0} * {32'd0, pcrng_pkg::MulA};
        pb = {32'd0, c2} * {32'd0, pcrng_pkg::MulB};
        n0 = pb[63:32] ^ c1 ^ k0;
        n2 = pa[63:32] ^ c3 ^ k1;
        c1 = pb[31:0];
        c3 = pa[31:0];
        c0 = n0;
        c2 = n2;
      end
      lanes[0] = c0;
      lanes[1] = c1;
      lanes[2] = c2;
      lanes[3] = c3;
      return lanes;
    endfunction

    function void note_block(logic [pcrng_pkg::BlockW-1:0] blk);
      bit [pcrng_pkg::WordW-1:0] first_index;
      bit [pcrng_pkg::WordW-1:0] lane_index;
      lane_words_t               lanes;
      philox_word_t              w;
      first_index = {blk, 2'b00};
      if (first_index >= element_total) return;
      lanes = philox_rounds(counter_base + 64'(blk));
      for (int lane = 0; lane < 4; lane++) begin
        lane_index = first_index + 32'(lane);
        if (lane_index < element_total) begin
          w.word  = lanes[lane];
          w.index = lane_index;
          w.last  = 1'b0;
          expected_words.insert(expected_words.size(), w);
        end
      end
      // lane 0 always goes out here, so the tail is this block's final word
      expected_words[expected_words.size()-1].last = 1'b1;
    endfunction

    function void check_word(logic [pcrng_pkg::WordW-1:0] word,
                             logic [pcrng_pkg::WordW-1:0] index, logic last);
      philox_word_t want;
      if (expected_words.size() == 0) begin
        $error("word %h at element %h arrived with nothing expected", word, index);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (word !== want.word) begin
        $error("random_word: expected %h, got %h", want.word, word);
        mismatches++;
      end
      if (index !== want.index) begin
        $error("element_index: expected %h, got %h", want.index, index);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_block: expected %b, got %b", want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

[dv/philox_counter_rng_block_test.sv]
// testbench top for the philox counter rng block: directed and random blocks, scoreboard check
`timescale 1ns / 1ps
module philox_counter_rng_block_test;

  typedef logic [pcrng_pkg::BlockW-1:0] blk_t;

  localparam logic [pcrng_pkg::CfgIdxW-1:0] RegUnknown = 8'hFF;
  localparam int unsigned DrainCycles    = pcrng_pkg::RoundCount + 6;
  localparam int unsigned WatchdogLimit  = 5000;
  localparam int unsigned RandomPhases   = 12;
  localparam int unsigned BlocksPerPhase = 36;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [pcrng_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pcrng_pkg::CfgDataW-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  blk_t                           in_block_number_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [pcrng_pkg::WordW-1:0]    out_random_word_o;
  logic [pcrng_pkg::WordW-1:0]    out_element_index_o;
  logic                           out_last_of_block_o;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;
  philox_word_scoreboard_pkg::philox_word_scoreboard words_sb;

  philox_counter_rng_block dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .in_block_number_i,
    .out_valid_o,
    .out_stall_i,
    .out_random_word_o,
    .out_element_index_o,
    .out_last_of_block_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (cfg_valid_i && cfg_ready_o) words_sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) words_sb.note_block(in_block_number_i);
      if (out_valid_o && !out_stall_i) begin
        words_sb.check_word(out_random_word_o, out_element_index_o, out_last_of_block_o);
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [pcrng_pkg::CfgIdxW-1:0] index,
                           input logic [pcrng_pkg::CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_generator(input logic [pcrng_pkg::WordW-1:0] kl,
                               input logic [pcrng_pkg::WordW-1:0] kh,
                               input logic [63:0] base,
                               input logic [pcrng_pkg::WordW-1:0] total);
    write_reg(pcrng_pkg::RegKeyLow, 64'(kl));
    write_reg(pcrng_pkg::RegKeyHigh, 64'(kh));
    write_reg(pcrng_pkg::RegCounterBase, base);
    write_reg(pcrng_pkg::RegElementTotal, 64'(total));
  endtask

  task automatic send_block(input blk_t blk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    in_block_number_i = blk;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // suppressed blocks leave no word behind, so allow the pipeline to empty too
  task automatic drain();
    in_valid_i = 1'b0;
    while (words_sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic blk_t pick_block(input logic [pcrng_pkg::WordW-1:0] total);
    blk_t        top_blk;
    int unsigned roll;
    top_blk = total[pcrng_pkg::WordW-1:2];
    roll    = $urandom_range(99);
    if (roll < 80) return blk_t'($urandom_range(top_blk));
    // around the block that straddles element_total
    if (roll < 90) return top_blk + blk_t'($urandom_range(2)) - 1'b1;
    return blk_t'($urandom);
  endfunction

  initial begin
    logic [pcrng_pkg::WordW-1:0] kl, kh, total;
    logic [63:0]                 base;
    words_sb          = new();
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    in_block_number_i = '0;
    send_gap_pct      = 19;
    recv_stall_pct    = 47;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // out of reset the element count is zero, nothing may come out
    send_block('0);
    send_block('1);
    drain();

    // full range; a write to an unmapped index must leave element_total alone
    set_generator('0, '0, '0, '1);
    write_reg(RegUnknown, '0);
    send_block(30'd0);
    send_block(30'd1);
    send_block(30'd2);
    send_block(30'h3FFFFFFF);
    send_block(30'h15555555);
    send_block(30'h2AAAAAAA);
    drain();

    // counter wraps past 2^64, partial third block, fourth block suppressed
    set_generator('1, '1, '1, 32'd10);
    send_block(30'd0);
    send_block(30'd1);
    send_block(30'd2);
    send_block(30'd3);
    send_block(30'h3FFFFFFF);
    drain();

    // carry from the low counter word into the high one
    set_generator(32'h01234567, 32'h89ABCDEF, 64'h0000_0000_FFFF_FFFF, 32'd7);
    send_block(30'd0);
    send_block(30'd1);
    send_block(30'd2);
    drain();

    write_reg(pcrng_pkg::RegElementTotal, 64'd1);
    send_block(30'd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p * 3 / RandomPhases)
        0: begin
          send_gap_pct   = 19;
          recv_stall_pct = 47;
        end
        1: begin
          send_gap_pct   = 47;
          recv_stall_pct = 19;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      kl = ($urandom_range(7) == 0) ? '1 : $urandom;
      kh = ($urandom_range(7) == 0) ? '0 : $urandom;
      case ($urandom_range(3))
        0:       base = {$urandom, $urandom};
        1:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(50));
        2:       base = 64'($urandom_range(1000));
        default: base = 64'h0000_0000_FFFF_FFFF - 64'($urandom_range(20));
      endcase
      case ($urandom_range(3))
        0:       total = '1;
        1:       total = $urandom;
        2:       total = $urandom_range(200, 1);
        default: total = 32'hFFFF_FFFF - $urandom_range(400);
      endcase
      set_generator(kl, kh, base, total);
      for (int i = 0; i < BlocksPerPhase; i++) send_block(pick_block(total));
      drain();
    end

    if (words_sb.mismatches == 0 && words_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
